// ===== rtl/rlbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rlbd_pkg
// Shared widths, request codes and state codes of the ladder button
// debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

package rlbd_pkg;

  localparam int SAMPLE_W = 12;
  localparam int BOUND_W  = 13;
  localparam int INDEX_W  = 5;

  // Input beat: sample_first, sample_second, entry_index, low_bound,
  // high_bound, one pad bit.
  localparam int S_TDATA_W = 56;

  localparam logic REQ_PROCESS = 1'b0;
  localparam logic REQ_WRITE   = 1'b1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/rlbd_visit.sv =====
// ----------------------------------------------------------------------------
// rlbd_visit
// Shared per-button unit: window compare, history shift and held/release
// decision for the one button the sequencer points at.
// ----------------------------------------------------------------------------
`default_nettype none

module rlbd_visit #(
  parameter int NUM_BUTTONS  = 18,
  parameter int HISTORY_BITS = 16,
  parameter int IDX_W        = 5
) (
  input  wire logic [rlbd_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [rlbd_pkg::BOUND_W-1:0]  low,
  input  wire logic [rlbd_pkg::BOUND_W-1:0]  high,
  input  wire logic [HISTORY_BITS-1:0]       hist,
  input  wire logic [NUM_BUTTONS-1:0]        held,
  input  wire logic [IDX_W-1:0]              idx,
  output logic      [HISTORY_BITS-1:0]       hist_next,
  output logic      [NUM_BUTTONS-1:0]        held_next,
  output logic                               release_hit
);
  import rlbd_pkg::*;

  logic [BOUND_W-1:0]     sample_ext;
  logic                   in_win;
  logic [NUM_BUTTONS-1:0] bit_sel;

  assign sample_ext = BOUND_W'(sample);
  assign in_win     = (sample_ext > low) && (sample_ext < high);
  assign bit_sel    = NUM_BUTTONS'(1) << idx;
  assign hist_next  = {hist[HISTORY_BITS-2:0], in_win};

  always_comb begin
    held_next   = held;
    release_hit = 1'b0;
    if (in_win) begin
      if (&hist_next) begin
        held_next = held | bit_sel;
      end
    end else if ((hist_next == '0) && (held == bit_sel)) begin
      // A release counts only when this button is the sole one held.
      held_next   = held & ~bit_sel;
      release_hit = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rlbd_store.sv =====
// ----------------------------------------------------------------------------
// rlbd_store
// Window bound table and press history registers, one entry per button.
// ----------------------------------------------------------------------------
`default_nettype none

module rlbd_store #(
  parameter int NUM_BUTTONS  = 18,
  parameter int HISTORY_BITS = 16,
  parameter int IDX_W        = 5
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         win_we,
  input  wire logic [IDX_W-1:0]             win_idx,
  input  wire logic [rlbd_pkg::BOUND_W-1:0] win_low_in,
  input  wire logic [rlbd_pkg::BOUND_W-1:0] win_high_in,
  input  wire logic [IDX_W-1:0]             rd_idx,
  input  wire logic                         hist_we,
  input  wire logic [HISTORY_BITS-1:0]      hist_wdata,
  output logic      [rlbd_pkg::BOUND_W-1:0] win_low,
  output logic      [rlbd_pkg::BOUND_W-1:0] win_high,
  output logic      [HISTORY_BITS-1:0]      hist
);
  import rlbd_pkg::*;

  logic [BOUND_W-1:0]      low_tab  [NUM_BUTTONS];
  logic [BOUND_W-1:0]      high_tab [NUM_BUTTONS];
  logic [HISTORY_BITS-1:0] hist_tab [NUM_BUTTONS];

  always_ff @(posedge clk) begin
    if (win_we) begin
      low_tab[win_idx]  <= win_low_in;
      high_tab[win_idx] <= win_high_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        hist_tab[i] <= '0;
      end
    end else if (hist_we) begin
      hist_tab[rd_idx] <= hist_wdata;
    end
  end

  assign win_low  = low_tab[rd_idx];
  assign win_high = high_tab[rd_idx];
  assign hist     = hist_tab[rd_idx];

endmodule

`default_nettype wire

// ===== rtl/resistor_ladder_button_debouncer_unit.sv =====
// ----------------------------------------------------------------------------
// resistor_ladder_button_debouncer_unit
// Debounces the buttons of two resistor ladders, one button per cycle.
// ----------------------------------------------------------------------------
// Usage: the s_ channel carries requests. tuser set writes the window bounds
// of button entry_index; tuser clear offers a sample pair, checked against
// every button's window in turn. Every request gives exactly one beat on the
// m_ channel: release flag, released button and the held mask.
// A table write goes from acceptance straight to the done state and then into
// the output register. A sample pair walks all 2*BUTTONS_PER_CHANNEL buttons
// through the shared compare/shift unit, one button per cycle, then passes the
// done state into the output register; s_tready rises in the same cycle as
// the result shows.
// The output beat sits in a register, so s_tready returns while a result
// still waits; a second result waits in the sequencer until m_tready frees
// the register.
// Reset clears all histories and held flags at once, and s_tready stays low
// while reset is held. Window entries are unknown until written and must be
// loaded before samples are sent.
// ----------------------------------------------------------------------------
`default_nettype none

module resistor_ladder_button_debouncer_unit #(
  parameter int BUTTONS_PER_CHANNEL = 9,
  parameter int HISTORY_BITS        = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // sample_first, sample_second, entry_index, low_bound, high_bound
  input  wire logic [rlbd_pkg::S_TDATA_W-1:0]    s_tdata,
  // req_type
  input  wire logic                              s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // released, released_button, held_mask
  output logic [((2*BUTTONS_PER_CHANNEL+6+7)/8)*8-1:0] m_tdata
);
  import rlbd_pkg::*;

  localparam int NUM_BUTTONS = 2 * BUTTONS_PER_CHANNEL;
  localparam int IDX_W       = $clog2(NUM_BUTTONS);
  localparam int M_TDATA_W   = ((NUM_BUTTONS + 6 + 7) / 8) * 8;

  logic [1:0]              state;
  logic [IDX_W-1:0]        cnt;
  logic [SAMPLE_W-1:0]     smp_first;
  logic [SAMPLE_W-1:0]     smp_second;
  logic [NUM_BUTTONS-1:0]  held;
  logic                    rel;
  logic [INDEX_W-1:0]      rel_btn;
  logic                    out_released;
  logic [INDEX_W-1:0]      out_button;
  logic [NUM_BUTTONS-1:0]  out_held;

  logic [SAMPLE_W-1:0]     in_first;
  logic [SAMPLE_W-1:0]     in_second;
  logic [INDEX_W-1:0]      in_index;
  logic [BOUND_W-1:0]      in_low;
  logic [BOUND_W-1:0]      in_high;

  logic                    accept;
  logic                    win_we;
  logic                    run;
  logic                    last;
  logic [SAMPLE_W-1:0]     cur_sample;
  logic [BOUND_W-1:0]      win_low;
  logic [BOUND_W-1:0]      win_high;
  logic [HISTORY_BITS-1:0] hist;
  logic [HISTORY_BITS-1:0] hist_next;
  logic [NUM_BUTTONS-1:0]  held_next;
  logic                    release_hit;
  logic                    out_free;

  assign in_first  = s_tdata[11:0];
  assign in_second = s_tdata[23:12];
  assign in_index  = s_tdata[28:24];
  assign in_low    = s_tdata[41:29];
  assign in_high   = s_tdata[54:42];

  assign s_tready = !rst && (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign win_we   = accept && (s_tuser == REQ_WRITE) &&
                    ({1'b0, in_index} < (INDEX_W + 1)'(NUM_BUTTONS));
  assign run      = (state == ST_RUN);
  assign last     = (cnt == IDX_W'(NUM_BUTTONS - 1));
  assign out_free = !m_tvalid || m_tready;

  // The first ladder channel serves the upper half of the buttons.
  assign cur_sample = ((IDX_W + 1)'(cnt) < (IDX_W + 1)'(BUTTONS_PER_CHANNEL)) ?
                      smp_second : smp_first;

  rlbd_store #(
    .NUM_BUTTONS  (NUM_BUTTONS),
    .HISTORY_BITS (HISTORY_BITS),
    .IDX_W        (IDX_W)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .win_we      (win_we),
    .win_idx     (in_index[IDX_W-1:0]),
    .win_low_in  (in_low),
    .win_high_in (in_high),
    .rd_idx      (cnt),
    .hist_we     (run),
    .hist_wdata  (hist_next),
    .win_low     (win_low),
    .win_high    (win_high),
    .hist        (hist)
  );

  rlbd_visit #(
    .NUM_BUTTONS  (NUM_BUTTONS),
    .HISTORY_BITS (HISTORY_BITS),
    .IDX_W        (IDX_W)
  ) u_visit (
    .sample      (cur_sample),
    .low         (win_low),
    .high        (win_high),
    .hist        (hist),
    .held        (held),
    .idx         (cnt),
    .hist_next   (hist_next),
    .held_next   (held_next),
    .release_hit (release_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      held     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cnt   <= '0;
            state <= (s_tuser == REQ_WRITE) ? ST_DONE : ST_RUN;
          end
        end
        ST_RUN: begin
          held <= held_next;
          cnt  <= cnt + 1'b1;
          if (last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers: latched samples, release tracking and the output beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      smp_first  <= in_first;
      smp_second <= in_second;
      rel        <= 1'b0;
      rel_btn    <= '0;
    end else if (run && release_hit) begin
      rel     <= 1'b1;
      rel_btn <= INDEX_W'(cnt);
    end
    if ((state == ST_DONE) && out_free) begin
      out_released <= rel;
      out_button   <= rel_btn;
      out_held     <= held;
    end
  end

  assign m_tdata = M_TDATA_W'({out_held, out_button, out_released});

  // A reported release leaves the released button's flag clear.
  a_release_clears_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !out_held[out_button])
    else $error("released button still marked as held");

  // A table write never walks the buttons.
  a_write_skips_walk: assert property (@(posedge clk) disable iff (rst)
    accept && (s_tuser == REQ_WRITE) |=> state == ST_DONE)
    else $error("table write entered the button walk");

  // The walk visits buttons in order, one per cycle.
  a_walk_steps: assert property (@(posedge clk) disable iff (rst)
    run && !last |=> run && (cnt == IDX_W'($past(cnt) + 1'b1)))
    else $error("button walk skipped or stalled");

endmodule

`default_nettype wire
